// ===== rtl/core/fast_atan2_polynomial_unit_defines.svh =====
// Assertion macros used by the checker file.
`ifndef FAST_ATAN2_POLYNOMIAL_UNIT_DEFINES_SVH
`define FAST_ATAN2_POLYNOMIAL_UNIT_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define ATP_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("atan2 unit check failed");

// Implication checked on every clock edge outside reset.
`define ATP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("atan2 unit implication failed");

`endif

// ===== rtl/core/atp_pkg.sv =====
`default_nettype none
package atp_pkg;

  localparam int CoordWidth    = 16;
  localparam int AngleFracBits = 13;
  localparam int AngleWidth    = AngleFracBits + 3;
  localparam int MagWidth      = CoordWidth;
  localparam int RatioWidth    = 16;
  localparam int DivStages     = RatioWidth;

  localparam logic [15:0] CoefC1  = 16'd32616;
  localparam logic [15:0] CoefC3  = 16'd9459;
  localparam logic [15:0] CoefC5  = 16'd2600;
  localparam logic [32:0] HalfQ15 = 33'd16384;

  localparam logic [63:0] PiQ32 = 64'h3243F6A88;
  localparam logic [63:0] PiQ64 =
    (PiQ32 + (64'd1 << (31 - AngleFracBits))) >> (32 - AngleFracBits);
  localparam logic [63:0] HalfPiQ64 =
    (PiQ32 + (64'd1 << (32 - AngleFracBits))) >> (33 - AngleFracBits);
  localparam logic [AngleWidth-1:0] PiQ     = PiQ64[AngleWidth-1:0];
  localparam logic [AngleWidth-1:0] HalfPiQ = HalfPiQ64[AngleWidth-1:0];

  // Q1.15 poly result down to the angle format, round half up
  localparam int          AngleShift = 15 - AngleFracBits;
  localparam logic [16:0] RoundAdd   = 17'd1 << (14 - AngleFracBits);

  typedef struct packed {
    logic signed [CoordWidth-1:0] x_coord;
    logic signed [CoordWidth-1:0] y_coord;
  } atp_in_t;

  typedef struct packed {
    logic signed [AngleWidth-1:0] angle;
    logic                         both_zero;
  } atp_out_t;

  // Octant and quadrant flags that ride along with the data
  typedef struct packed {
    logic both_zero;
    logic steep;
    logic x_neg;
    logic y_neg;
  } atp_side_t;

endpackage
`default_nettype wire

// ===== rtl/core/atp_div.sv =====
`default_nettype none
// Restoring divider, one quotient bit per stage: r = (min << 15) / max.
module atp_div import atp_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  en_i,
  input  wire logic                  vld_i,
  input  wire logic [MagWidth-1:0]   min_i,
  input  wire logic [MagWidth-1:0]   max_i,
  input  wire atp_side_t             side_i,
  output logic                       vld_o,
  output logic [RatioWidth-1:0]      ratio_o,
  output atp_side_t                  side_o
);

  logic              vld_q  [DivStages];
  logic [MagWidth:0] rem_q  [DivStages];
  logic [MagWidth-1:0] max_q [DivStages];
  logic [RatioWidth-1:0] quo_q [DivStages];
  atp_side_t         side_q [DivStages];

  for (genvar i = 0; i < DivStages; i++) begin : g_stage
    logic [MagWidth:0]     rem_in;
    logic [MagWidth-1:0]   dvs;
    logic [RatioWidth-1:0] quo_in;
    logic                  vld_in;
    atp_side_t             side_in;
    logic                  ge;
    logic [MagWidth:0]     rem_d;
    logic [RatioWidth-1:0] quo_d;

    if (i == 0) begin : g_first
      assign rem_in  = {1'b0, min_i};
      assign dvs     = max_i;
      assign quo_in  = '0;
      assign vld_in  = vld_i;
      assign side_in = side_i;
    end else begin : g_next
      // remainder stays below the divisor, so the shift never overflows
      assign rem_in  = {rem_q[i-1][MagWidth-1:0], 1'b0};
      assign dvs     = max_q[i-1];
      assign quo_in  = quo_q[i-1];
      assign vld_in  = vld_q[i-1];
      assign side_in = side_q[i-1];
    end

    always_comb begin
      ge    = rem_in >= {1'b0, dvs};
      rem_d = ge ? (rem_in - {1'b0, dvs}) : rem_in;
      quo_d = {quo_in[RatioWidth-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i]  <= rem_d;
        max_q[i]  <= dvs;
        quo_q[i]  <= quo_d;
        side_q[i] <= side_in;
      end
    end
  end

  assign vld_o   = vld_q[DivStages-1];
  assign ratio_o = quo_q[DivStages-1];
  assign side_o  = side_q[DivStages-1];

endmodule
`default_nettype wire

// ===== rtl/core/atp_poly.sv =====
`default_nettype none
// Horner evaluation of r*(C1 - r^2*(C3 - C5*r^2)) in Q1.15, one product per stage.
module atp_poly import atp_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  en_i,
  input  wire logic                  vld_i,
  input  wire logic [RatioWidth-1:0] ratio_i,
  input  wire atp_side_t             side_i,
  output logic                       vld_o,
  output logic [15:0]                poly_o,
  output atp_side_t                  side_o
);

  logic [3:0]  vld_q;
  atp_side_t   side_q [4];
  logic [15:0] r1_q, r2_q, r3_q;
  logic [15:0] sq1_q, sq2_q;
  logic [15:0] t_q, v_q, a_q;

  logic [32:0] sq_d, t_d, v_d, a_d;
  logic [15:0] u_w, p_w;

  // operands widened first so no product bits are lost
  always_comb begin
    sq_d = {17'd0, ratio_i} * {17'd0, ratio_i} + HalfQ15;
    t_d  = {17'd0, sq1_q} * {17'd0, CoefC5} + HalfQ15;
    u_w  = CoefC3 - t_q;
    v_d  = {17'd0, sq2_q} * {17'd0, u_w} + HalfQ15;
    p_w  = CoefC1 - v_q;
    a_d  = {17'd0, r3_q} * {17'd0, p_w} + HalfQ15;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq1_q     <= sq_d[30:15];
      r1_q      <= ratio_i;
      side_q[0] <= side_i;

      t_q       <= t_d[30:15];
      sq2_q     <= sq1_q;
      r2_q      <= r1_q;
      side_q[1] <= side_q[0];

      v_q       <= v_d[30:15];
      r3_q      <= r2_q;
      side_q[2] <= side_q[1];

      a_q       <= a_d[30:15];
      side_q[3] <= side_q[2];
    end
  end

  assign vld_o  = vld_q[3];
  assign poly_o = a_q;
  assign side_o = side_q[3];

endmodule
`default_nettype wire

// ===== rtl/core/fast_atan2_polynomial_unit.sv =====
`default_nettype none
// Four-quadrant arctangent of a signed (x, y) pair, angle in Q3.13 radians.
// Input channel: in_valid_i / in_stall_o with in_data_i {x_coord, y_coord}.
// Output channel: out_valid_o / out_stall_i with out_data_o {angle, both_zero}.
// A transaction completes on a clock edge with valid high and stall low.
// Pipeline: input register, 16 divider stages, 4 multiplier stages,
// output register. Throughput: one transaction per cycle while not stalled.
// The depth is set by the ratio divider, which resolves one quotient
// bit per stage.
// Both inputs zero gives angle 0 with both_zero set.
// Reset clears all valid bits; the pipeline comes up empty.
// When the receiver stalls a valid result, the whole pipeline freezes and
// in_stall_o rises in the same cycle; nothing is dropped or repeated.
module fast_atan2_polynomial_unit import atp_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_stall_o,
  input  wire atp_in_t in_data_i,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  output atp_out_t     out_data_o
);

  logic en;

  logic                in_vld_q;
  logic [MagWidth-1:0] in_min_q, in_max_q;
  atp_side_t           in_side_q;

  logic [MagWidth-1:0] ax, ay;
  atp_side_t           side_d;

  logic                  div_vld;
  logic [RatioWidth-1:0] div_ratio;
  atp_side_t             div_side;

  logic        poly_vld;
  logic [15:0] poly_a;
  atp_side_t   poly_side;

  logic                  out_vld_q;
  atp_out_t              out_q;
  logic [16:0]           a_rnd;
  logic [AngleWidth-1:0] base0, base1, base2, ang_d;

  assign en         = !(out_vld_q && out_stall_i);
  assign in_stall_o = !en;

  always_comb begin
    ax = in_data_i.x_coord[CoordWidth-1] ? MagWidth'(-in_data_i.x_coord)
                                         : MagWidth'(in_data_i.x_coord);
    ay = in_data_i.y_coord[CoordWidth-1] ? MagWidth'(-in_data_i.y_coord)
                                         : MagWidth'(in_data_i.y_coord);
    side_d.both_zero = (ax == '0) && (ay == '0);
    side_d.steep     = ay > ax;
    side_d.x_neg     = in_data_i.x_coord[CoordWidth-1];
    side_d.y_neg     = in_data_i.y_coord[CoordWidth-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      in_vld_q  <= in_valid_i;
      out_vld_q <= poly_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      in_min_q  <= side_d.steep ? ax : ay;
      in_max_q  <= side_d.steep ? ay : ax;
      in_side_q <= side_d;
    end
  end

  atp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .vld_i   (in_vld_q),
    .min_i   (in_min_q),
    .max_i   (in_max_q),
    .side_i  (in_side_q),
    .vld_o   (div_vld),
    .ratio_o (div_ratio),
    .side_o  (div_side)
  );

  atp_poly u_poly (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .vld_i   (div_vld),
    .ratio_i (div_ratio),
    .side_i  (div_side),
    .vld_o   (poly_vld),
    .poly_o  (poly_a),
    .side_o  (poly_side)
  );

  // Octant and quadrant fold
  always_comb begin
    a_rnd = {1'b0, poly_a} + RoundAdd;
    base0 = AngleWidth'(a_rnd >> AngleShift);
    base1 = poly_side.steep ? (HalfPiQ - base0) : base0;
    base2 = poly_side.x_neg ? (PiQ - base1) : base1;
    ang_d = poly_side.y_neg ? (~base2 + 1'b1) : base2;
    if (poly_side.both_zero) begin
      ang_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.angle     <= ang_d;
      out_q.both_zero <= poly_side.both_zero;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

// ===== rtl/core/atp_checker.sv =====
`default_nettype none
`include "fast_atan2_polynomial_unit_defines.svh"
module atp_checker import atp_pkg::*; (
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     in_valid_i,
  input wire logic     in_stall_o,
  input wire atp_in_t  in_data_i,
  input wire logic     out_valid_o,
  input wire logic     out_stall_i,
  input wire atp_out_t out_data_o
);

  logic signed [AngleWidth-1:0] pi_s;
  assign pi_s = PiQ;

  // input side only backs up behind a stalled result
  `ATP_ASSERT_IMP(a_stall_cause, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i)
  `ATP_ASSERT_IMP(a_zero_angle, clk_i, rst_ni, out_valid_o && out_data_o.both_zero,
                  out_data_o.angle == '0)
  `ATP_ASSERT_IMP(a_angle_range, clk_i, rst_ni, out_valid_o,
                  (out_data_o.angle <= pi_s) && (out_data_o.angle >= -pi_s))
  `ATP_ASSERT(a_out_hold, clk_i, rst_ni,
              (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))

endmodule

bind fast_atan2_polynomial_unit atp_checker u_atp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
`default_nettype wire
